// File: design/segment_tree_point_add_range_sum_assert.svh
// Assertion macros used by the tree's sequencer.
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STPRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/stprs_pkg.sv
`timescale 1ns / 1ps

package stprs_pkg;

  localparam int SUM_W    = 32;
  localparam int WEIGHT_W = 16;
  localparam int POS_W    = 10;
  localparam int BOUND_W  = 11;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_SUM = 1'b1;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_res_t;

endpackage

// File: design/segment_tree_point_add_range_sum.sv
`timescale 1ns / 1ps
// Point-add / range-sum tree over LEAF_COUNT leaves, node sums in one RAM.
// Input channel (in_valid / in_stall): in_func 0 adds in_weight to leaf
// in_position and its ancestors, no result; in_func 1 returns the sum of
// leaves [in_range_start, in_range_end) on out_valid / out_range_sum.
// Bounds above LEAF_COUNT saturate; an add beyond the last leaf is dropped.
// Config: cfg_we writes cfg_wdata as the count of leading leaves set to one
// and rebuilds the tree, discarding earlier adds.
// Build, after reset and after each config write: a write of each leaf,
// then two child reads and a write for each inner node, from the last
// inner node down to the root; no item is taken meanwhile.
// One item at a time. A point add holds the sequencer for a read-then-write
// of the leaf and of each ancestor up to the root on the single RAM read port.
// A range sum takes a low-bound and a high-bound step per level walked, then
// a final check and a done step, before its result is loaded into the output
// register.
// The output register holds a result while out_stall is high; a finished
// query waits for it to free up, and no new item is accepted until the
// sequencer is back to idle.
module segment_tree_point_add_range_sum #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [stprs_pkg::BOUND_W-1:0]          cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic [stprs_pkg::POS_W-1:0]            in_position,
  input  logic signed [stprs_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [stprs_pkg::BOUND_W-1:0]          in_range_start,
  input  logic [stprs_pkg::BOUND_W-1:0]          in_range_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [stprs_pkg::SUM_W-1:0]     out_range_sum
);

  localparam int AW = $clog2(2*LEAF_COUNT);
  localparam int IW = $clog2(2*LEAF_COUNT+1);
  localparam int SW = stprs_pkg::SUM_W;

  logic [stprs_pkg::BOUND_W-1:0] ones_r;
  logic [IW-1:0]                 ones_clamp;
  stprs_pkg::sum_res_t           res;
  logic                          res_stall;
  logic                          out_valid_r;
  logic [SW-1:0]                 out_range_sum_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  assign ones_clamp = (32'(ones_r) > 32'(LEAF_COUNT)) ? IW'(LEAF_COUNT) : IW'(ones_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r <= '0;
    end else if (cfg_we) begin
      ones_r <= cfg_wdata;
    end
  end

  assign res_stall = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_range_sum_r <= res.sum;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_range_sum_r;

  stprs_seq #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .build_start   (cfg_we),
    .ones          (ones_clamp),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_weight     (in_weight),
    .in_range_start(in_range_start),
    .in_range_end  (in_range_end),
    .res           (res),
    .res_stall     (res_stall),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  stprs_ram #(
    .WIDTH(SW),
    .DEPTH(2*LEAF_COUNT)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// File: design/stprs_ram.sv
`timescale 1ns / 1ps

module stprs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/stprs_seq.sv
`timescale 1ns / 1ps
`include "segment_tree_point_add_range_sum_assert.svh"

module stprs_seq #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   build_start,
  input  logic [$clog2(2*LEAF_COUNT+1)-1:0]      ones,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic [stprs_pkg::POS_W-1:0]            in_position,
  input  logic signed [stprs_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [stprs_pkg::BOUND_W-1:0]          in_range_start,
  input  logic [stprs_pkg::BOUND_W-1:0]          in_range_end,
  output stprs_pkg::sum_res_t                    res,
  input  logic                                   res_stall,
  output logic                                   ram_we,
  output logic [$clog2(2*LEAF_COUNT)-1:0]        ram_waddr,
  output logic [stprs_pkg::SUM_W-1:0]            ram_wdata,
  output logic [$clog2(2*LEAF_COUNT)-1:0]        ram_raddr,
  input  logic [stprs_pkg::SUM_W-1:0]            ram_rdata
);

  localparam int AW = $clog2(2*LEAF_COUNT);
  localparam int IW = $clog2(2*LEAF_COUNT+1);
  localparam int SW = stprs_pkg::SUM_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_BLEAF = 10'b00_0000_0010,
    S_BRD0  = 10'b00_0000_0100,
    S_BRD1  = 10'b00_0000_1000,
    S_BWR   = 10'b00_0001_0000,
    S_URD   = 10'b00_0010_0000,
    S_UWR   = 10'b00_0100_0000,
    S_QLO   = 10'b00_1000_0000,
    S_QHI   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } seq_state_t;

  seq_state_t    state_r, state_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;   // leaf counter, node index or low bound
  logic [IW-1:0] hi_r, hi_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic          pend_r, pend_nxt; // a read issued last cycle adds to acc
  logic [SW-1:0] d0_r, d0_nxt;
  logic [SW-1:0] delta_r, delta_nxt;

  logic [SW-1:0] acc_add;
  logic [31:0]   lo_clamp;
  logic [31:0]   hi_clamp;

  assign acc_add  = acc_r + (pend_r ? ram_rdata : '0);
  assign lo_clamp = (32'(in_range_start) > 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT)
                                                             : 32'(in_range_start);
  assign hi_clamp = (32'(in_range_end) > 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT)
                                                           : 32'(in_range_end);

  assign in_stall = (state_r != S_IDLE) || build_start;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    hi_nxt    = hi_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    d0_nxt    = d0_r;
    delta_nxt = delta_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_r[AW-1:0];
    ram_wdata = '0;
    ram_raddr = ptr_r[AW-1:0];
    res.valid = 1'b0;
    res.sum   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == stprs_pkg::FUNC_ADD) begin
            // adds beyond the last leaf are dropped
            if (32'(in_position) < 32'(LEAF_COUNT)) begin
              ptr_nxt   = IW'(32'(LEAF_COUNT) + 32'(in_position));
              delta_nxt = SW'(in_weight);
              state_nxt = S_URD;
            end
          end else begin
            ptr_nxt   = IW'(lo_clamp + 32'(LEAF_COUNT));
            hi_nxt    = IW'(hi_clamp + 32'(LEAF_COUNT));
            acc_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_QLO;
          end
        end
      end
      S_BLEAF: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(32'(LEAF_COUNT) + 32'(ptr_r));
        ram_wdata = (ptr_r < ones) ? SW'(1) : '0;
        if (ptr_r == IW'(LEAF_COUNT - 1)) begin
          state_nxt = S_BRD0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_BRD0: begin
        ram_raddr = AW'({ptr_r, 1'b0});
        state_nxt = S_BRD1;
      end
      S_BRD1: begin
        ram_raddr = AW'({ptr_r, 1'b1});
        d0_nxt    = ram_rdata;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        ram_we    = 1'b1;
        ram_wdata = d0_r + ram_rdata;
        if (ptr_r == IW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = S_BRD0;
        end
      end
      S_URD: begin
        state_nxt = S_UWR;
      end
      S_UWR: begin
        // tree stays consistent, so each ancestor just takes the delta
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + delta_r;
        if (ptr_r == IW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r >> 1;
          state_nxt = S_URD;
        end
      end
      S_QLO: begin
        acc_nxt  = acc_add;
        pend_nxt = 1'b0;
        if (ptr_r >= hi_r) begin
          state_nxt = S_DONE;
        end else begin
          if (ptr_r[0]) begin
            pend_nxt = 1'b1;
            ptr_nxt  = ptr_r + 1'b1;
          end
          state_nxt = S_QHI;
        end
      end
      S_QHI: begin
        acc_nxt  = acc_add;
        pend_nxt = 1'b0;
        if (hi_r[0]) begin
          ram_raddr = AW'(hi_r - 1'b1);
          pend_nxt  = 1'b1;
        end
        // odd hi: (hi - 1) >> 1 equals hi >> 1
        hi_nxt    = hi_r >> 1;
        ptr_nxt   = ptr_r >> 1;
        state_nxt = S_QLO;
      end
      S_DONE: begin
        if (!res_stall) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (build_start) begin
      state_nxt = S_BLEAF;
      ptr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BLEAF;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    acc_r   <= acc_nxt;
    d0_r    <= d0_nxt;
    delta_r <= delta_nxt;
  end

  `STPRS_ASSERT_NOW(a_query_order, clk, rst_n, state_r == S_QHI, ptr_r <= hi_r, "query bounds crossed mid-level")
  `STPRS_ASSERT_NEXT(a_update_ends, clk, rst_n, state_r == S_UWR && ptr_r == IW'(1) && !build_start, state_r == S_IDLE, "update did not stop at root")
  `STPRS_ASSERT_NEXT(a_build_ends, clk, rst_n, state_r == S_BWR && ptr_r == IW'(1) && !build_start, state_r == S_IDLE, "build did not stop at root")

endmodule
